// ===== rtl/core/ckd_pkg.sv =====
// Types, constants, ROMs and decode functions shared by the chord keyboard decoder.
`default_nettype none

package ckd_pkg;

  localparam logic [1:0] KIND_RELEASE = 2'd0;
  localparam logic [1:0] KIND_PRESS   = 2'd1;

  typedef enum logic [2:0] {
    KEY_NONE,
    KEY_SHIFT,
    KEY_SPACE,
    KEY_LETTER,
    KEY_DIGIT
  } key_class_t;

  typedef struct packed {
    key_class_t cls;
    logic [7:0] finger;
    logic       five;
    logic       six;
  } key_info_t;

  typedef struct packed {
    logic [4:0] thumb;
    logic [7:0] chord;
  } ckd_state_t;

  typedef struct packed {
    logic       valid;
    logic       backspace;
    logic [6:0] code;
  } decode_t;

  localparam logic [4:0] FLAG_SHIFT   = 5'h01;
  localparam logic [4:0] FLAG_SPACE   = 5'h02;
  localparam logic [4:0] FLAG_FIVE    = 5'h04;
  localparam logic [4:0] FLAG_SIX     = 5'h08;
  localparam logic [4:0] FLAG_NUMERIC = 5'h10;

  localparam logic [4:0] THUMB_LOWER     = 5'h00;
  localparam logic [4:0] THUMB_UPPER     = FLAG_SHIFT;
  localparam logic [4:0] THUMB_ENTER     = FLAG_SHIFT | FLAG_SPACE;
  localparam logic [4:0] THUMB_NUMERAL   = FLAG_NUMERIC;
  localparam logic [4:0] THUMB_SYMBOL    = FLAG_NUMERIC | FLAG_SHIFT;
  localparam logic [4:0] THUMB_FIVE      = FLAG_NUMERIC | FLAG_FIVE;
  localparam logic [4:0] THUMB_FIVE_SH   = FLAG_NUMERIC | FLAG_FIVE | FLAG_SHIFT;
  localparam logic [4:0] THUMB_SIX       = FLAG_NUMERIC | FLAG_SIX;
  localparam logic [4:0] THUMB_SIX_SH    = FLAG_NUMERIC | FLAG_SIX | FLAG_SHIFT;
  localparam logic [4:0] THUMB_FIVE_SIX  = FLAG_NUMERIC | FLAG_FIVE | FLAG_SIX;

  localparam logic [7:0] CHORD_BACKSPACE = 8'h11;

  localparam logic [6:0] CHAR_BACKSPACE = 7'h08;
  localparam logic [6:0] CHAR_NEWLINE   = 7'h0A;
  localparam logic [6:0] CHAR_SPACE     = 7'h20;
  localparam logic [6:0] CHAR_PERCENT   = 7'h25;
  localparam logic [6:0] CHAR_FIVE      = 7'h35;
  localparam logic [6:0] CHAR_SIX       = 7'h36;
  localparam logic [6:0] CHAR_CARET     = 7'h5E;

  localparam logic [7:0] DIGIT_FINGER [0:9] = '{
    8'h01, 8'h80, 8'h40, 8'h20, 8'h10, 8'h00, 8'h00, 8'h08, 8'h04, 8'h02
  };

  // Row h of each layer starts at TRI_BASE[h] and holds the columns l = 0..h.
  localparam logic [5:0] TRI_BASE [0:7] = '{
    6'd0, 6'd1, 6'd3, 6'd6, 6'd10, 6'd15, 6'd21, 6'd28
  };

  localparam logic [6:0] LAYER_ROM [0:3][0:35] = '{
    '{7'h70, 7'h3B, 7'h6F, 7'h6B, 7'h6C, 7'h69, 7'h6D, 7'h75, 7'h68, 7'h6E,
      7'h08, 7'h67, 7'h76, 7'h62, 7'h74, 7'h27, 7'h2D, 7'h2C, 7'h79, 7'h72,
      7'h65, 7'h29, 7'h2E, 7'h7A, 7'h6A, 7'h63, 7'h64, 7'h73, 7'h3F, 7'h28,
      7'h21, 7'h71, 7'h66, 7'h78, 7'h77, 7'h61},
    '{7'h50, 7'h3A, 7'h4F, 7'h4B, 7'h4C, 7'h49, 7'h4D, 7'h55, 7'h48, 7'h4E,
      7'h7F, 7'h47, 7'h56, 7'h42, 7'h54, 7'h22, 7'h5F, 7'h3C, 7'h59, 7'h52,
      7'h45, 7'h1B, 7'h3E, 7'h5A, 7'h4A, 7'h43, 7'h44, 7'h53, 7'h2F, 7'h1E,
      7'h1E, 7'h51, 7'h46, 7'h58, 7'h57, 7'h41},
    '{7'h30, 7'h3B, 7'h39, 7'h5C, 7'h3D, 7'h38, 7'h5D, 7'h0E, 7'h04, 7'h37,
      7'h08, 7'h13, 7'h12, 7'h11, 7'h34, 7'h27, 7'h2D, 7'h2C, 7'h02, 7'h01,
      7'h33, 7'h29, 7'h2E, 7'h3D, 7'h03, 7'h0E, 7'h2D, 7'h32, 7'h3F, 7'h28,
      7'h21, 7'h00, 7'h5B, 7'h60, 7'h0F, 7'h31},
    '{7'h29, 7'h3A, 7'h28, 7'h7C, 7'h2B, 7'h2A, 7'h7D, 7'h0E, 7'h04, 7'h26,
      7'h08, 7'h13, 7'h12, 7'h11, 7'h24, 7'h22, 7'h5F, 7'h3C, 7'h02, 7'h01,
      7'h23, 7'h1B, 7'h3E, 7'h2B, 7'h03, 7'h0E, 7'h5F, 7'h40, 7'h2F, 7'h1E,
      7'h1E, 7'h00, 7'h7B, 7'h7E, 7'h0F, 7'h21}
  };

  function automatic key_info_t classify_key(input logic [7:0] sc);
    key_info_t  k;
    logic [3:0] dval;
    k.cls    = KEY_NONE;
    k.finger = 8'h00;
    k.five   = 1'b0;
    k.six    = 1'b0;
    dval     = 4'd0;
    if (sc == 8'd42 || (sc >= 8'd44 && sc <= 8'd47) || sc == 8'd54) begin
      k.cls = KEY_SHIFT;
    end else if ((sc >= 8'd49 && sc <= 8'd52) || sc == 8'd57) begin
      k.cls = KEY_SPACE;
    end else if (sc >= 8'd2 && sc <= 8'd11) begin
      k.cls = KEY_DIGIT;
      dval  = (sc == 8'd11) ? 4'd0 : 4'(sc - 8'd1);
    end else if (sc >= 8'd200 && sc <= 8'd209) begin
      k.cls = KEY_DIGIT;
      dval  = 4'(sc - 8'd200);
    end else if (sc >= 8'd16 && sc <= 8'd19) begin
      k.cls    = KEY_LETTER;
      k.finger = 8'h80 >> (sc - 8'd16);
    end else if (sc >= 8'd30 && sc <= 8'd33) begin
      k.cls    = KEY_LETTER;
      k.finger = 8'h80 >> (sc - 8'd30);
    end else if (sc >= 8'd22 && sc <= 8'd25) begin
      k.cls    = KEY_LETTER;
      k.finger = 8'h08 >> (sc - 8'd22);
    end else if (sc >= 8'd36 && sc <= 8'd39) begin
      k.cls    = KEY_LETTER;
      k.finger = 8'h08 >> (sc - 8'd36);
    end
    if (k.cls == KEY_DIGIT) begin
      k.five   = (dval == 4'd5);
      k.six    = (dval == 4'd6);
      k.finger = DIGIT_FINGER[dval];
    end
    return k;
  endfunction

  // Only chords of one or two fingers have an entry in the layer ROMs.
  function automatic logic [6:0] rom_lookup(input logic [1:0] layer, input logic [7:0] chord);
    logic [2:0] hi;
    logic [2:0] lo;
    logic       seen;
    logic [7:0] pair;
    logic [5:0] idx;
    hi   = 3'd0;
    lo   = 3'd0;
    seen = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (chord[i]) begin
        if (!seen) begin
          lo   = 3'(i);
          seen = 1'b1;
        end
        hi = 3'(i);
      end
    end
    pair = (8'h01 << hi) | (8'h01 << lo);
    idx  = TRI_BASE[hi] + 6'(lo);
    if (chord == 8'h00 || chord != pair) begin
      return 7'h00;
    end
    return LAYER_ROM[layer][idx];
  endfunction

  function automatic decode_t decode_state(input ckd_state_t s);
    decode_t d;
    d.valid     = 1'b0;
    d.backspace = 1'b0;
    d.code      = 7'h00;
    if (s.thumb == THUMB_ENTER && s.chord == 8'h00) begin
      d.code = CHAR_NEWLINE;
    end else if (s.thumb == FLAG_SPACE && s.chord == 8'h00) begin
      d.code = CHAR_SPACE;
    end else if (s.chord == CHORD_BACKSPACE) begin
      d.backspace = 1'b1;
    end else begin
      unique case (s.thumb)
        THUMB_LOWER:    d.code = rom_lookup(2'd0, s.chord);
        THUMB_UPPER:    d.code = rom_lookup(2'd1, s.chord);
        THUMB_NUMERAL:  d.code = rom_lookup(2'd2, s.chord);
        THUMB_SYMBOL:   d.code = rom_lookup(2'd3, s.chord);
        THUMB_FIVE:     d.code = CHAR_FIVE;
        THUMB_FIVE_SH:  d.code = CHAR_PERCENT;
        THUMB_SIX:      d.code = CHAR_SIX;
        THUMB_SIX_SH:   d.code = CHAR_CARET;
        THUMB_FIVE_SIX: d.code = CHAR_NEWLINE;
        default:        d.code = 7'h00;
      endcase
    end
    d.valid = d.backspace || (d.code != 7'h00);
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/chord_keyboard_decoder_core.sv =====
// Chord keyboard decoder: key events in, ASCII characters out.
//
// The input channel carries one key event per transfer: the scancode in
// in_tdata and the event kind (release, press, autorepeat) in in_tuser.
// The result channel carries one ASCII character per transfer in out_tdata,
// with out_tlast marking the final character caused by an event.
// A press updates the held chord and thumb flags; a release of any key other
// than shift decodes the held chord into zero, one or three characters and
// clears the held state. Autorepeat events change nothing.
// The held state sits in a one-entry synchronous memory whose registered
// read port is loaded with the written value, so an event may follow in the
// very next cycle. A character appears on the output in the cycle after its
// event is accepted, and one event is accepted per cycle while the output
// register is free or is handing over its final character.
// The backspace chord gives three characters and holds off the input while
// its leading characters are transferred; a stalled receiver holds off the
// input the same way.
// Reset clears the output register and marks the held state as empty; no
// sweep of the memory is needed.
`default_nettype none

module chord_keyboard_decoder_core
  import ckd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] scan_code
  input  wire logic [1:0] in_tuser,   // [1:0] event_kind
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [6:0] char_code, [7] zero
  output logic            out_tlast
);

  typedef enum logic [1:0] {
    BS_NONE,
    BS_SPACE,
    BS_TAIL
  } bs_step_t;

  ckd_state_t state_mem [0:0];
  ckd_state_t state_rd_r;
  logic       state_vld_r;
  ckd_state_t cur_state;
  ckd_state_t state_nxt;

  key_info_t  key;
  decode_t    dec;
  decode_t    emit;
  logic       in_fire;
  logic       out_free;

  logic       out_valid_r;
  logic [6:0] out_code_r;
  logic       out_last_r;
  bs_step_t   bs_r;

  assign out_free  = !out_valid_r || (out_tready && out_last_r);
  assign in_tready = out_free;
  assign in_fire   = in_tvalid && in_tready;

  assign cur_state = state_vld_r ? state_rd_r : '0;
  assign key       = classify_key(in_tdata);
  assign dec       = decode_state(cur_state);

  always_comb begin
    state_nxt = cur_state;
    emit      = '0;
    case (in_tuser)
      KIND_PRESS: begin
        unique case (key.cls)
          KEY_SHIFT: state_nxt.thumb = cur_state.thumb ^ FLAG_SHIFT;
          KEY_SPACE: state_nxt.thumb = cur_state.thumb | FLAG_SPACE;
          KEY_LETTER: begin
            state_nxt.thumb = cur_state.thumb & ~FLAG_NUMERIC;
            state_nxt.chord = cur_state.chord | key.finger;
          end
          KEY_DIGIT: begin
            state_nxt.thumb = cur_state.thumb | FLAG_NUMERIC
                              | (key.five ? FLAG_FIVE : 5'h00)
                              | (key.six ? FLAG_SIX : 5'h00);
            state_nxt.chord = cur_state.chord | key.finger;
          end
          default: ;
        endcase
      end
      KIND_RELEASE: begin
        if (key.cls != KEY_SHIFT) begin
          emit      = dec;
          state_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      state_mem[0] <= state_nxt;
      state_rd_r   <= state_nxt;
    end else begin
      state_rd_r   <= state_mem[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_vld_r <= 1'b0;
    end else if (in_fire) begin
      state_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_code_r  <= 7'h00;
      out_last_r  <= 1'b0;
      bs_r        <= BS_NONE;
    end else if (in_fire && emit.valid) begin
      out_valid_r <= 1'b1;
      if (emit.backspace) begin
        out_code_r <= CHAR_BACKSPACE;
        out_last_r <= 1'b0;
        bs_r       <= BS_SPACE;
      end else begin
        out_code_r <= emit.code;
        out_last_r <= 1'b1;
        bs_r       <= BS_NONE;
      end
    end else if (out_valid_r && out_tready) begin
      unique case (bs_r)
        BS_SPACE: begin
          out_code_r <= CHAR_SPACE;
          bs_r       <= BS_TAIL;
        end
        BS_TAIL: begin
          out_code_r <= CHAR_BACKSPACE;
          out_last_r <= 1'b1;
          bs_r       <= BS_NONE;
        end
        default: out_valid_r <= 1'b0;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_code_r};
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

// ===== rtl/core/ckd_port_chk.sv =====
// Port-level checker for the chord keyboard decoder and its bind statement.
`default_nettype none

module ckd_port_chk
  import ckd_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tready,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tlast
);

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("Result withdrawn before its transfer.");

  // Characters are seven-bit ASCII.
  a_ascii: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7] == 1'b0)
    else $error("Result character has its top bit set.");

  // Only the backspace sequence has characters that are not final.
  a_seq_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |->
      (out_tdata == {1'b0, CHAR_BACKSPACE} || out_tdata == {1'b0, CHAR_SPACE}))
    else $error("Non-final character outside the backspace sequence.");

  // The backspace sequence continues right after each leading transfer.
  a_seq_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("Backspace sequence broken off.");

  // The input is held off only while a result is pending.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("Input stalled with an empty output.");

endmodule

bind chord_keyboard_decoder_core ckd_port_chk u_ckd_port_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
